FILE: hdl/psd_pkg.sv
// Shared widths, types and helpers for the point to segment distance pipeline.
package psd_pkg;

	// coordinate format
	localparam int COORD_W   = 24;
	localparam int FRAC_BITS = 10;
	localparam int U_BITS    = 24;              // fraction bits of the projection parameter
	localparam int GUARD     = 31 - COORD_W;    // extra fraction bits kept on the foot point

	// derived widths
	localparam int DIFF_W  = COORD_W + 1;       // coordinate difference
	localparam int PROD_W  = 2 * DIFF_W;        // difference product
	localparam int LEN_W   = 2 * COORD_W + 2;   // squared length, also divider remainder
	localparam int DOT_W   = 2 * DIFF_W + 1;    // dot product
	localparam int Q_W     = U_BITS + 1;        // raw quotient bits
	localparam int T_W     = U_BITS + 1;        // projection parameter, up to 2^U_BITS
	localparam int TPROD_W = T_W + 1 + DIFF_W;  // parameter times difference
	localparam int FULL_W  = COORD_W + U_BITS + 4;
	localparam int DELTA_W = 32;                // foot minus point, Q(FRAC_BITS+GUARD)
	localparam int SUM_W   = 2 * DELTA_W;       // squared distance
	localparam int DIST_W  = COORD_W + 1;

	localparam int DIV_STEPS  = Q_W;
	localparam int SQRT_STEPS = SUM_W / 2;

	// configuration
	localparam int MINSQ_W = 21;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [MINSQ_W-1:0] MINSQ_RESET =
		MINSQ_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd50) / 64'd100);
	localparam logic [PADDR_W-3:0] REG_MINSQ = '0;

	// projection parameter class
	typedef enum logic [1:0] {
		TCLS_ZERO,
		TCLS_ONE,
		TCLS_DIV
	} tcls_t;

	// sideband carried along the divider row
	typedef struct packed {
		logic                        valid;
		logic                        degen;
		tcls_t                       tcls;
		logic signed [COORD_W-1:0]   sx;
		logic signed [COORD_W-1:0]   sy;
		logic signed [COORD_W-1:0]   px;
		logic signed [COORD_W-1:0]   py;
		logic signed [DIFF_W-1:0]    lx;
		logic signed [DIFF_W-1:0]    ly;
	} div_tag_t;

	// sideband carried along the square root row
	typedef struct packed {
		logic valid;
		logic degen;
	} sqrt_tag_t;

	// trial bit of square root step k, starting at the top even bit
	function automatic logic [SUM_W-1:0] sqrt_bit(input int k);
		return SUM_W'(1) << (SUM_W - 2 - 2 * k);
	endfunction

endpackage

FILE: hdl/psd_div_cell.sv
// One restoring division step: shift the remainder, subtract when it fits.
module psd_div_cell import psd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [LEN_W-1:0] rem_in,
	input  logic [LEN_W-1:0] den_in,
	input  logic [Q_W-1:0]   quo_in,
	input  div_tag_t         tag_in,
	output logic [LEN_W-1:0] rem_q,
	output logic [LEN_W-1:0] den_q,
	output logic [Q_W-1:0]   quo_q,
	output div_tag_t         tag_q
);

	logic [LEN_W:0]   shifted;
	logic [LEN_W:0]   diff;
	logic             fits;
	logic [LEN_W-1:0] rem_next;

	// remainder stays below the divisor, so the shifted value is below twice it
	assign shifted  = {rem_in, 1'b0};
	assign diff     = shifted - {1'b0, den_in};
	assign fits     = shifted >= {1'b0, den_in};
	assign rem_next = fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_next;
			den_q <= den_in;
			quo_q <= {quo_in[Q_W-2:0], fits};
		end
	end

endmodule

FILE: hdl/psd_sqrt_cell.sv
// One digit-by-digit square root step for a fixed trial bit.
module psd_sqrt_cell import psd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [SUM_W-1:0] val_in,
	input  logic [SUM_W-1:0] root_in,
	input  logic [SUM_W-1:0] bit_in,
	input  sqrt_tag_t        tag_in,
	output logic [SUM_W-1:0] val_q,
	output logic [SUM_W-1:0] root_q,
	output sqrt_tag_t        tag_q
);

	logic [SUM_W-1:0] trial;
	logic             take;

	assign trial = root_in + bit_in;
	assign take  = val_in >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_q  <= take ? (val_in - trial) : val_in;
			root_q <= take ? ((root_in >> 1) + bit_in) : (root_in >> 1);
		end
	end

endmodule

FILE: hdl/point_segment_distance.sv
// Top level: point to segment distance pipeline with APB threshold register.
//
//  channel  | handshake               | beat
//  ---------+-------------------------+---------------------------------------
//  in       | in_valid / in_ready     | point_x, point_y, start_x, start_y,
//           |                         | end_x, end_y
//  out      | out_valid / out_ready   | distance, degenerate
//  cfg      | psel, penable, pwrite   | paddr, pwdata, prdata (pready tied 1)
//
// One beat per cycle in and out while the output is not stalled. Stages: four front,
// 25 divider cells, six foot and square stages, 32 square root cells, output.
// The divider row and the square root row set the depth.
// Reset clears all valid bits and loads the threshold with its default.
// A stalled output beat holds the whole row only when the last cell is full,
// so a bubble ahead of the output is squeezed out and input keeps flowing.
module point_segment_distance import psd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	// output channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [DIST_W-1:0]         distance,
	output logic                      degenerate,
	// configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready
);

	localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (GUARD - 1);
	localparam logic [SUM_W-1:0] DIST_MAX   = (SUM_W'(1) << DIST_W) - SUM_W'(1);
	localparam logic [FULL_W-1:0] FOOT_HALF = FULL_W'(1) << (U_BITS - GUARD - 1);

	logic en;
	logic out_load;

	// threshold register
	logic [MINSQ_W-1:0] minsq_q;
	logic               reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:2] == REG_MINSQ;
	assign prdata  = reg_hit ? PDATA_W'(minsq_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minsq_q <= MINSQ_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			minsq_q <= pwdata[MINSQ_W-1:0];
		end
	end

	// front stages
	div_tag_t                  tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [DIFF_W-1:0]  qx_s1, qy_s1;
	logic signed [PROD_W-1:0]  lxx_s2, lyy_s2, dpx_s2, dpy_s2;
	logic [LEN_W-1:0]          len2_s3;
	logic signed [DOT_W-1:0]   dot_s3;
	logic [LEN_W-1:0]          rem_s4, den_s4;
	div_tag_t                  tag_next_s4;

	// classify the projection and the degenerate case
	always_comb begin
		tag_next_s4       = tag_s3;
		tag_next_s4.degen = len2_s3 < LEN_W'(minsq_q);
		if (dot_s3[DOT_W-1] || dot_s3 == '0) begin
			tag_next_s4.tcls = TCLS_ZERO;
		end else if (dot_s3 >= $signed({1'b0, len2_s3})) begin
			tag_next_s4.tcls = TCLS_ONE;
		end else begin
			tag_next_s4.tcls = TCLS_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (en) begin
			tag_s1.valid <= in_valid;
			tag_s1.degen <= 1'b0;
			tag_s1.tcls  <= TCLS_ZERO;
			tag_s1.sx    <= start_x;
			tag_s1.sy    <= start_y;
			tag_s1.px    <= point_x;
			tag_s1.py    <= point_y;
			tag_s1.lx    <= DIFF_W'(end_x) - DIFF_W'(start_x);
			tag_s1.ly    <= DIFF_W'(end_y) - DIFF_W'(start_y);
			tag_s2       <= tag_s1;
			tag_s3       <= tag_s2;
			tag_s4       <= tag_next_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s1   <= DIFF_W'(point_x) - DIFF_W'(start_x);
			qy_s1   <= DIFF_W'(point_y) - DIFF_W'(start_y);
			lxx_s2  <= tag_s1.lx * tag_s1.lx;
			lyy_s2  <= tag_s1.ly * tag_s1.ly;
			dpx_s2  <= qx_s1 * tag_s1.lx;
			dpy_s2  <= qy_s1 * tag_s1.ly;
			len2_s3 <= $unsigned(lxx_s2) + $unsigned(lyy_s2);
			dot_s3  <= DOT_W'(dpx_s2) + DOT_W'(dpy_s2);
			rem_s4  <= (tag_next_s4.tcls == TCLS_DIV) ? dot_s3[LEN_W-1:0] : '0;
			den_s4  <= len2_s3;
		end
	end

	// divider row
	logic [LEN_W-1:0] rem_d [DIV_STEPS+1];
	logic [LEN_W-1:0] den_d [DIV_STEPS+1];
	logic [Q_W-1:0]   quo_d [DIV_STEPS+1];
	div_tag_t         tag_d [DIV_STEPS+1];

	assign rem_d[0] = rem_s4;
	assign den_d[0] = den_s4;
	assign quo_d[0] = '0;
	assign tag_d[0] = tag_s4;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		psd_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.rem_in (rem_d[k]),
			.den_in (den_d[k]),
			.quo_in (quo_d[k]),
			.tag_in (tag_d[k]),
			.rem_q  (rem_d[k+1]),
			.den_q  (den_d[k+1]),
			.quo_q  (quo_d[k+1]),
			.tag_q  (tag_d[k+1])
		);
	end

	// parameter, foot point and squared distance
	div_tag_t                  tag_s5, tag_s6, tag_s7;
	sqrt_tag_t                 tag_s8, tag_s9, tag_s10;
	logic [T_W-1:0]            t_s5;
	logic [T_W-1:0]            t_next;
	logic [Q_W:0]              quo_round;
	logic signed [TPROD_W-1:0] prodx_s6, prody_s6;
	logic signed [FULL_W-1:0]  fullx_s7, fully_s7;
	logic signed [FULL_W-1:0]  footx, footy;
	logic signed [DELTA_W-1:0] dx_s8, dy_s8;
	logic signed [SUM_W-1:0]   sqx_s9, sqy_s9;
	logic [SUM_W-1:0]          sum_s10;

	// round the quotient half up
	assign quo_round = (Q_W+1)'(quo_d[DIV_STEPS]) + (Q_W+1)'(1);

	always_comb begin
		case (tag_d[DIV_STEPS].tcls)
			TCLS_ONE: t_next = T_W'(1) << U_BITS;
			TCLS_DIV: t_next = quo_round[Q_W:1];
			default:  t_next = '0;
		endcase
	end

	assign footx = fullx_s7 >>> (U_BITS - GUARD);
	assign footy = fully_s7 >>> (U_BITS - GUARD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5  <= '0;
			tag_s6  <= '0;
			tag_s7  <= '0;
			tag_s8  <= '0;
			tag_s9  <= '0;
			tag_s10 <= '0;
		end else if (en) begin
			tag_s5        <= tag_d[DIV_STEPS];
			tag_s6        <= tag_s5;
			tag_s7        <= tag_s6;
			tag_s8.valid  <= tag_s7.valid;
			tag_s8.degen  <= tag_s7.degen;
			tag_s9        <= tag_s8;
			tag_s10       <= tag_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s5     <= t_next;
			prodx_s6 <= $signed({1'b0, t_s5}) * tag_s5.lx;
			prody_s6 <= $signed({1'b0, t_s5}) * tag_s5.ly;
			fullx_s7 <= (FULL_W'(tag_s6.sx) <<< U_BITS) + FULL_W'(prodx_s6) + FOOT_HALF;
			fully_s7 <= (FULL_W'(tag_s6.sy) <<< U_BITS) + FULL_W'(prody_s6) + FOOT_HALF;
			dx_s8    <= footx[DELTA_W-1:0] - (DELTA_W'(tag_s7.px) <<< GUARD);
			dy_s8    <= footy[DELTA_W-1:0] - (DELTA_W'(tag_s7.py) <<< GUARD);
			sqx_s9   <= dx_s8 * dx_s8;
			sqy_s9   <= dy_s8 * dy_s8;
			sum_s10  <= $unsigned(sqx_s9) + $unsigned(sqy_s9);
		end
	end

	// square root row
	logic [SUM_W-1:0] val_r  [SQRT_STEPS+1];
	logic [SUM_W-1:0] root_r [SQRT_STEPS+1];
	sqrt_tag_t        tag_r  [SQRT_STEPS+1];

	assign val_r[0]  = sum_s10;
	assign root_r[0] = '0;
	assign tag_r[0]  = tag_s10;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		psd_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.val_in  (val_r[k]),
			.root_in (root_r[k]),
			.bit_in  (sqrt_bit(k)),
			.tag_in  (tag_r[k]),
			.val_q   (val_r[k+1]),
			.root_q  (root_r[k+1]),
			.tag_q   (tag_r[k+1])
		);
	end

	// flow control: the row moves unless a full last cell faces a held output
	assign out_load = out_ready || !out_valid;
	assign en       = out_load || !tag_r[SQRT_STEPS].valid;
	assign in_ready = en;

	// output register: round away the guard bits and saturate, or give zero on a degenerate beat
	logic              out_valid_q;
	logic [DIST_W-1:0] distance_q;
	logic              degenerate_q;
	logic [SUM_W-1:0]  dist_round;

	assign dist_round = (root_r[SQRT_STEPS] + ROUND_HALF) >> GUARD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= tag_r[SQRT_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			degenerate_q <= tag_r[SQRT_STEPS].degen;
			if (tag_r[SQRT_STEPS].degen) begin
				distance_q <= '0;
			end else if (dist_round > DIST_MAX) begin
				distance_q <= DIST_MAX[DIST_W-1:0];
			end else begin
				distance_q <= dist_round[DIST_W-1:0];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign distance   = distance_q;
	assign degenerate = degenerate_q;

	// checks
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> distance == '0)
		else $error("degenerate beat with nonzero distance");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> tag_s1.valid)
		else $error("accepted beat did not enter the first stage");

	a_zero_param: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s5.valid && tag_s5.tcls == TCLS_ZERO |-> t_s5 == '0)
		else $error("projection parameter not zero for start clamp");

	a_held_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && tag_r[SQRT_STEPS].valid |=> !en || out_ready)
		else $error("row advanced into a held output");

endmodule

FILE: tb/tb_top.sv
// Testbench for the point to segment distance pipeline: random and directed beats, scoreboard check.
`timescale 1ns / 1ps

import psd_pkg::*;

// expected distance beats and their comparison
class distance_scoreboard;
	logic [DIST_W-1:0] exp_dist[$];
	logic              exp_degen[$];
	int                errors;
	logic [MINSQ_W-1:0] min_len2;

	function new();
		errors   = 0;
		min_len2 = MINSQ_RESET;
	endfunction

	// round to nearest, half up, of num/den in Q0.U_BITS; 0 < num < den
	function automatic longint unsigned proj_div(longint unsigned num, longint unsigned den);
		longint unsigned r, q;
		r = num;
		q = 0;
		for (int i = 0; i < U_BITS + 1; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return (q + 1) >> 1;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// foot coordinate minus point, Q(FRAC_BITS+GUARD); >>> floors on signed values
	function automatic longint foot_offset(longint s, longint l, longint t, longint p);
		longint full;
		full = s * (64'sd1 <<< U_BITS) + t * l;
		full = (full + (64'sd1 <<< (U_BITS - GUARD - 1))) >>> (U_BITS - GUARD);
		return full - p * (64'sd1 <<< GUARD);
	endfunction

	// note an accepted input beat
	function void note_segment(longint px, longint py, longint sx, longint sy,
			longint ex, longint ey);
		longint lx, ly, len2, dot, t, dx, dy;
		longint unsigned sum, r, dval;
		lx   = ex - sx;
		ly   = ey - sy;
		len2 = lx * lx + ly * ly;
		if (len2 < longint'(min_len2)) begin
			exp_dist.push_back('0);
			exp_degen.push_back(1'b1);
			return;
		end
		dot = (px - sx) * lx + (py - sy) * ly;
		if (dot <= 0) t = 0;
		else if (dot >= len2) t = 64'sd1 <<< U_BITS;
		else t = longint'(proj_div(dot, len2));
		dx = foot_offset(sx, lx, t, px);
		dy = foot_offset(sy, ly, t, py);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		sum  = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
		r    = int_sqrt(sum);
		dval = (r + (64'd1 << (GUARD - 1))) >> GUARD;
		if (dval > (64'd1 << DIST_W) - 1) dval = (64'd1 << DIST_W) - 1;
		exp_dist.push_back(dval[DIST_W-1:0]);
		exp_degen.push_back(1'b0);
	endfunction

	// check one output beat
	function void check_beat(logic [DIST_W-1:0] got_dist, logic degen);
		logic [DIST_W-1:0] ed;
		logic              eg;
		if (exp_dist.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected beat: dist=%0d degen=%0b", got_dist, degen);
			return;
		end
		ed = exp_dist.pop_front();
		eg = exp_degen.pop_front();
		if (got_dist !== ed || degen !== eg) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: dist exp %0d got %0d, degen exp %0b got %0b",
					ed, got_dist, eg, degen);
		end
	endfunction
endclass

module tb_top;
	localparam int LATENCY = 68;
	localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

	logic                      clk, arst_n;
	logic                      in_valid, in_ready;
	logic signed [COORD_W-1:0] point_x, point_y, start_x, start_y, end_x, end_y;
	logic                      out_valid, out_ready;
	logic [DIST_W-1:0]         distance;
	logic                      degenerate;
	logic                      psel, penable, pwrite;
	logic [PADDR_W-1:0]        paddr;
	logic [PDATA_W-1:0]        pwdata, prdata;
	logic                      pready;

	distance_scoreboard sb;
	bit                 hold_off;

	point_segment_distance uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scoreboard hooks at each accepted beat
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_segment(point_x, point_y, start_x, start_y, end_x, end_y);
		if (arst_n && out_valid && out_ready)
			sb.check_beat(distance, degenerate);
	end

	// random gap length: mostly short, a few long
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// receiver stalls, with a long hold-off on request
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic cfg_write(logic [MINSQ_W-1:0] v);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(REG_MINSQ) << 2;
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.min_len2 = v;
	endtask

	// send one beat; gaps=0 allows back-to-back valid
	task automatic send_seg(logic signed [COORD_W-1:0] px, py, sx, sy, ex, ey, bit gaps);
		int n;
		n = gaps ? gap_len() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px; point_y <= py;
		start_x <= sx; start_y <= sy;
		end_x   <= ex; end_y   <= ey;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.exp_dist.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] rnd_coord(int mode);
		case (mode)
			0: return COORD_W'($urandom);
			1: return COORD_W'($signed($urandom_range(0, 8191)) - 4096);
			default: return COORD_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	task automatic random_phase(int count, bit gaps);
		logic signed [COORD_W-1:0] sx, sy, ex, ey;
		int m;
		for (int i = 0; i < count; i++) begin
			m  = $urandom_range(0, 2);
			sx = rnd_coord(m);
			sy = rnd_coord(m);
			case ($urandom_range(0, 5))
				0: begin ex = sx + COORD_W'($signed($urandom_range(0, 200)) - 100);
					ey = sy + COORD_W'($signed($urandom_range(0, 200)) - 100); end
				1: begin ex = sx; ey = sy; end
				default: begin ex = rnd_coord(m); ey = rnd_coord(m); end
			endcase
			send_seg(rnd_coord(m), rnd_coord(m), sx, sy, ex, ey, gaps);
		end
	endtask

	initial begin
		sb       = new();
		arst_n   = 1'b0;
		in_valid = 1'b0;
		point_x  = '0; point_y = '0; start_x = '0; start_y = '0; end_x = '0; end_y = '0;
		psel     = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default threshold, degenerate and clamp cases
		send_seg(0, 0, 0, 0, 0, 0, 0);                // zero length, degenerate
		send_seg(1024, 1024, 0, 0, 100, 0, 0);        // short, degenerate
		send_seg(-500, 700, 0, 0, 1024, 0, 0);        // projection before start
		send_seg(3000, -700, 0, 0, 1024, 0, 0);       // beyond the end
		send_seg(512, 300, 0, 0, 1024, 0, 0);         // inside
		send_seg(1024, 0, 0, 0, 1024, 0, 0);          // exactly at end
		send_seg(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, 0);
		send_seg(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, 0);
		send_seg(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 0);
		send_seg(CMIN, CMAX, CMAX, CMAX, CMAX, CMAX - 1, 0);
		send_seg(-1, -1, CMIN, 0, CMAX, 0, 0);
		send_seg(CMAX, CMAX, CMIN, CMIN, CMIN + 1, CMIN, 0);
		drain();

		// threshold 0: zero length not flagged
		cfg_write('0);
		send_seg(CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, 0);
		send_seg(5, -7, 3, 3, 3, 3, 0);
		send_seg(200, 90, 0, 0, 1, 0, 0);
		random_phase(150, 1);
		drain();

		// threshold 2^20, plus exact boundary
		cfg_write(MINSQ_W'(1048576));
		send_seg(0, 0, 0, 0, 1024, 0, 0);             // len2 == threshold
		send_seg(0, 0, 0, 0, 1023, 0, 0);
		random_phase(150, 1);
		drain();

		// all threshold bits high
		cfg_write('1);
		random_phase(100, 1);
		drain();

		// back to default; fill the pipe under a long output stall
		cfg_write(MINSQ_RESET);
		hold_off = 1;
		random_phase(150, 0);
		drain();

		cfg_write(MINSQ_W'($urandom_range(0, 1048576)));
		random_phase(300, 1);
		drain();

		if (sb.errors == 0 && sb.exp_dist.size() == 0)
			$display("[point_segment_distance] OK");
		else
			$display("[point_segment_distance] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("[point_segment_distance] ERROR");
		$finish;
	end
endmodule

FILE: files.f
hdl/psd_pkg.sv
hdl/psd_div_cell.sv
hdl/psd_sqrt_cell.sv
hdl/point_segment_distance.sv
tb/tb_top.sv
